// ===== hw/rtl/cpu_idle_percent_smoother_unit_assert.svh =====
// assertion macros shared by the smoother rtl
`ifndef CPU_IDLE_PERCENT_SMOOTHER_UNIT_ASSERT_SVH
`define CPU_IDLE_PERCENT_SMOOTHER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CIPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CIPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CIPS_ASSERT_IMP(lbl, ante, cons, msg)
`define CIPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/cips_pkg.sv =====
// types, constants and microcode program of the cpu idle percent smoother
package cips_pkg;

    localparam int NUM_CNT       = 8;
    localparam int CNT_IDX_W     = $clog2(NUM_CNT);
    localparam int TICK_W        = 64;
    localparam int IDLE_IDX      = 3;
    localparam int CFG_W         = 7;
    localparam int DEFAULT_DEPTH = 30;
    localparam int MAX_DEPTH     = 64;
    localparam int PCT_W         = 7;
    localparam int FULL_PCT      = 100;
    localparam int AVG_W         = 15;
    localparam int FULL_Q8       = 25600;
    localparam int Q8_SHIFT      = 8;
    localparam int POS_W         = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int SUM_W         = $clog2(MAX_DEPTH * FULL_PCT + 1);
    localparam int AVG_Q_W       = SUM_W + Q8_SHIFT;
    localparam int NUM_W         = TICK_W + PCT_W;
    localparam int DIV_W         = (NUM_W > CFG_W + AVG_Q_W) ? NUM_W : CFG_W + AVG_Q_W;
    localparam int LOOP_W        = CFG_W;
    localparam int PC_W          = 5;
    localparam int IN_W          = NUM_CNT * TICK_W;
    localparam int OUT_W         = 16;

    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_ACC,
        OP_TOTAL,
        OP_NUM_A,
        OP_NUM_B,
        OP_NUM_C,
        OP_NUM_D,
        OP_DIV,
        OP_RING,
        OP_RD_START,
        OP_SUM,
        OP_AVG_INIT,
        OP_EMIT_AVG,
        OP_PRIME,
        OP_REPEAT
    } op_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_FIRE,
        C_UNPRIMED,
        C_LOOP_NZ,
        C_TOTAL_ZERO,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   tgt_t;
        pc_t   tgt_f;
    } ctrl_t;

    typedef struct packed {
        logic in_fire;
        logic primed;
        logic total_zero;
        logic loop_nz;
        logic out_free;
    } status_t;

    localparam pc_t P_WAIT      = 5'd0;
    localparam pc_t P_CHECK     = 5'd1;
    localparam pc_t P_ACC       = 5'd2;
    localparam pc_t P_TOTAL     = 5'd3;
    localparam pc_t P_ZERO      = 5'd4;
    localparam pc_t P_NUM_A     = 5'd5;
    localparam pc_t P_NUM_B     = 5'd6;
    localparam pc_t P_NUM_C     = 5'd7;
    localparam pc_t P_NUM_D     = 5'd8;
    localparam pc_t P_PCT_DIV   = 5'd9;
    localparam pc_t P_RING      = 5'd10;
    localparam pc_t P_RD_START  = 5'd11;
    localparam pc_t P_SUM       = 5'd12;
    localparam pc_t P_AVG_INIT  = 5'd13;
    localparam pc_t P_AVG_DIV   = 5'd14;
    localparam pc_t P_EMIT_AVG  = 5'd15;
    localparam pc_t P_PRIME     = 5'd16;
    localparam pc_t P_REPEAT    = 5'd17;

    function automatic ctrl_t cw(input op_t op, input cond_t cond, input pc_t t, input pc_t f);
        ctrl_t w;
        w.op    = op;
        w.cond  = cond;
        w.tgt_t = t;
        w.tgt_f = f;
        return w;
    endfunction

    function automatic ctrl_t rom(input pc_t pc);
        ctrl_t w;
        unique case (pc)
            P_WAIT:     w = cw(OP_CAPTURE,  C_IN_FIRE,    P_CHECK,    P_WAIT);
            P_CHECK:    w = cw(OP_NOP,      C_UNPRIMED,   P_PRIME,    P_ACC);
            P_ACC:      w = cw(OP_ACC,      C_LOOP_NZ,    P_ACC,      P_TOTAL);
            P_TOTAL:    w = cw(OP_TOTAL,    C_ALWAYS,     P_ZERO,     P_ZERO);
            P_ZERO:     w = cw(OP_NOP,      C_TOTAL_ZERO, P_REPEAT,   P_NUM_A);
            P_NUM_A:    w = cw(OP_NUM_A,    C_ALWAYS,     P_NUM_B,    P_NUM_B);
            P_NUM_B:    w = cw(OP_NUM_B,    C_ALWAYS,     P_NUM_C,    P_NUM_C);
            P_NUM_C:    w = cw(OP_NUM_C,    C_ALWAYS,     P_NUM_D,    P_NUM_D);
            P_NUM_D:    w = cw(OP_NUM_D,    C_ALWAYS,     P_PCT_DIV,  P_PCT_DIV);
            P_PCT_DIV:  w = cw(OP_DIV,      C_LOOP_NZ,    P_PCT_DIV,  P_RING);
            P_RING:     w = cw(OP_RING,     C_ALWAYS,     P_RD_START, P_RD_START);
            P_RD_START: w = cw(OP_RD_START, C_ALWAYS,     P_SUM,      P_SUM);
            P_SUM:      w = cw(OP_SUM,      C_LOOP_NZ,    P_SUM,      P_AVG_INIT);
            P_AVG_INIT: w = cw(OP_AVG_INIT, C_ALWAYS,     P_AVG_DIV,  P_AVG_DIV);
            P_AVG_DIV:  w = cw(OP_DIV,      C_LOOP_NZ,    P_AVG_DIV,  P_EMIT_AVG);
            P_EMIT_AVG: w = cw(OP_EMIT_AVG, C_OUT_FREE,   P_WAIT,     P_EMIT_AVG);
            P_PRIME:    w = cw(OP_PRIME,    C_OUT_FREE,   P_WAIT,     P_PRIME);
            P_REPEAT:   w = cw(OP_REPEAT,   C_OUT_FREE,   P_WAIT,     P_REPEAT);
            default:    w = cw(OP_NOP,      C_ALWAYS,     P_WAIT,     P_WAIT);
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/cips_ram.sv =====
// generic single write port ram with registered read
module cips_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/cips_seq.sv =====
// microcode sequencer: step counter, control rom and branch logic
module cips_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  cips_pkg::status_t  status,
    output cips_pkg::ctrl_t    ctrl
);

    cips_pkg::pc_t pc_reg;
    cips_pkg::pc_t pc_next;
    logic          take;

    assign ctrl = cips_pkg::rom(pc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            cips_pkg::C_ALWAYS:     take = 1'b1;
            cips_pkg::C_IN_FIRE:    take = status.in_fire;
            cips_pkg::C_UNPRIMED:   take = !status.primed;
            cips_pkg::C_LOOP_NZ:    take = status.loop_nz;
            cips_pkg::C_TOTAL_ZERO: take = status.total_zero;
            cips_pkg::C_OUT_FREE:   take = status.out_free;
            default:                take = 1'b1;
        endcase
        pc_next = take ? ctrl.tgt_t : ctrl.tgt_f;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= cips_pkg::P_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== hw/rtl/cpu_idle_percent_smoother_unit.sv =====
// cpu idle percent smoother: microcoded datapath around a ring of idle percentages
// the first item primes, a zero-total item repeats the last average, others run the full
// program to the result register; one item in flight, the next taken in the cycle after that
// time is set by the 8-step counter sum, a shared shift-subtract divider (7 and 21
// steps) and a depth-long ring sum through the single ram read port
// reset: ring reads as 100 through per-entry valid bits, no clearing pass, depth 30
module cpu_idle_percent_smoother_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // user, nice, system, idle, iowait, irq, softirq, steal ticks (64 bits each)
    input  logic [cips_pkg::IN_W-1:0]     s_axis_tdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // idle_pct_q8 [14:0], zero [15]
    output logic [cips_pkg::OUT_W-1:0]    m_axis_tdata,
    // sampled [0]
    output logic [0:0]                    m_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [cips_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready
);

`include "cpu_idle_percent_smoother_unit_assert.svh"

    localparam int TW = cips_pkg::TICK_W;
    localparam int DW = cips_pkg::DIV_W;
    localparam int QW = cips_pkg::AVG_Q_W;
    localparam int PW = cips_pkg::PCT_W;
    localparam int LW = cips_pkg::LOOP_W;
    localparam int SW = cips_pkg::SUM_W;
    localparam int AW = cips_pkg::AVG_W;
    localparam int RW = cips_pkg::POS_W;
    localparam int CW = cips_pkg::CFG_W;
    localparam int NC = cips_pkg::NUM_CNT;

    cips_pkg::ctrl_t   ctrl;
    cips_pkg::status_t status;

    logic [TW-1:0]          in_reg [NC];
    logic [TW-1:0]          in_next [NC];
    logic [TW-1:0]          prev_reg [NC];
    logic [TW-1:0]          prev_next [NC];
    logic [TW-1:0]          acc_in_reg, acc_in_next;
    logic [TW-1:0]          acc_prev_reg, acc_prev_next;
    logic [TW-1:0]          total_reg, total_next;
    logic [TW-1:0]          idle_reg, idle_next;
    logic [DW-1:0]          rem_reg, rem_next;
    logic [DW-1:0]          dv_reg, dv_next;
    logic [QW-1:0]          q_reg, q_next;
    logic [SW-1:0]          sum_reg, sum_next;
    logic [RW-1:0]          ra_reg, ra_next;
    logic                   rd_valid_reg, rd_valid_next;

    logic [LW-1:0]          loop_reg, loop_next;
    logic                   primed_reg, primed_next;
    logic [RW-1:0]          pos_reg, pos_next;
    logic [cips_pkg::MAX_DEPTH-1:0] valid_reg, valid_next;
    logic [AW-1:0]          last_avg_reg, last_avg_next;
    logic [CW-1:0]          cfg_reg, cfg_next;
    logic                   out_valid_reg, out_valid_next;
    logic [AW-1:0]          out_data_reg, out_data_next;
    logic                   out_sampled_reg, out_sampled_next;

    logic [CW-1:0]          d_raw;
    logic [CW-1:0]          d_eff;
    logic [RW:0]            pos_plus;
    logic [RW-1:0]          pos_new;
    logic [DW:0]            diff;
    logic                   ge;
    logic [PW-1:0]          pct_clamp;
    logic [PW-1:0]          ram_rdata;
    logic [PW-1:0]          rd_pct;
    logic                   ram_we;
    logic                   in_fire;
    logic                   out_free;

    cips_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    cips_ram #(
        .WIDTH (PW),
        .DEPTH (cips_pkg::MAX_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_new),
        .wdata (pct_clamp),
        .raddr (ra_reg),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (ctrl.op == cips_pkg::OP_CAPTURE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    // depth only changes while no item is in flight
    assign cfg_ready     = (ctrl.op == cips_pkg::OP_CAPTURE);

    assign status.in_fire    = in_fire;
    assign status.primed     = primed_reg;
    assign status.total_zero = (total_reg == '0);
    assign status.loop_nz    = (loop_reg != '0);
    assign status.out_free   = out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg};
    assign m_axis_tuser  = out_sampled_reg;

    // effective depth: zero means default, saturate at ring size
    assign d_raw = (cfg_reg == '0) ? CW'(cips_pkg::DEFAULT_DEPTH) : cfg_reg;
    assign d_eff = (32'(d_raw) > cips_pkg::MAX_DEPTH) ? CW'(cips_pkg::MAX_DEPTH) : d_raw;

    assign pos_plus = {1'b0, pos_reg} + (RW+1)'(1);
    assign pos_new  = (32'(pos_plus) >= 32'(d_eff)) ? '0 : pos_plus[RW-1:0];

    assign diff = {1'b0, rem_reg} - {1'b0, dv_reg};
    assign ge   = !diff[DW];

    assign pct_clamp = (q_reg[PW-1:0] > PW'(cips_pkg::FULL_PCT)) ?
                       PW'(cips_pkg::FULL_PCT) : q_reg[PW-1:0];
    assign rd_pct    = rd_valid_reg ? ram_rdata : PW'(cips_pkg::FULL_PCT);
    assign ram_we    = (ctrl.op == cips_pkg::OP_RING);

    always_comb
    begin
        in_next          = in_reg;
        prev_next        = prev_reg;
        acc_in_next      = acc_in_reg;
        acc_prev_next    = acc_prev_reg;
        total_next       = total_reg;
        idle_next        = idle_reg;
        rem_next         = rem_reg;
        dv_next          = dv_reg;
        q_next           = q_reg;
        sum_next         = sum_reg;
        ra_next          = ra_reg;
        rd_valid_next    = valid_reg[ra_reg];
        loop_next        = loop_reg;
        primed_next      = primed_reg;
        pos_next         = pos_reg;
        valid_next       = valid_reg;
        last_avg_next    = last_avg_reg;
        cfg_next         = (cfg_valid && cfg_ready) ? cfg_data : cfg_reg;
        out_valid_next   = m_axis_tready ? 1'b0 : out_valid_reg;
        out_data_next    = out_data_reg;
        out_sampled_next = out_sampled_reg;

        unique case (ctrl.op)
            cips_pkg::OP_NOP:
            begin
            end
            cips_pkg::OP_CAPTURE:
            begin
                if (in_fire)
                begin
                    for (int k = 0; k < NC; k++)
                    begin
                        in_next[k] = s_axis_tdata[k*TW +: TW];
                    end
                    acc_in_next   = '0;
                    acc_prev_next = '0;
                    loop_next     = LW'(NC - 1);
                end
            end
            cips_pkg::OP_ACC:
            begin
                acc_in_next   = acc_in_reg + in_reg[loop_reg[cips_pkg::CNT_IDX_W-1:0]];
                acc_prev_next = acc_prev_reg + prev_reg[loop_reg[cips_pkg::CNT_IDX_W-1:0]];
                loop_next     = loop_reg - LW'(1);
            end
            cips_pkg::OP_TOTAL:
            begin
                total_next = acc_in_reg - acc_prev_reg;
                idle_next  = in_reg[cips_pkg::IDLE_IDX] - prev_reg[cips_pkg::IDLE_IDX];
            end
            // 100 * idle as 64 + 32 + 4 times idle
            cips_pkg::OP_NUM_A:
            begin
                rem_next = DW'(idle_reg) << 6;
            end
            cips_pkg::OP_NUM_B:
            begin
                rem_next = rem_reg + (DW'(idle_reg) << 5);
            end
            cips_pkg::OP_NUM_C:
            begin
                rem_next = rem_reg + (DW'(idle_reg) << 2);
            end
            cips_pkg::OP_NUM_D:
            begin
                rem_next  = rem_reg + DW'(total_reg >> 1);
                dv_next   = DW'(total_reg) << (PW - 1);
                q_next    = '0;
                loop_next = LW'(PW - 1);
            end
            cips_pkg::OP_DIV:
            begin
                if (ge)
                begin
                    rem_next = diff[DW-1:0];
                end
                q_next    = {q_reg[QW-2:0], ge};
                dv_next   = dv_reg >> 1;
                loop_next = loop_reg - LW'(1);
            end
            cips_pkg::OP_RING:
            begin
                pos_next            = pos_new;
                valid_next[pos_new] = 1'b1;
                prev_next           = in_reg;
                sum_next            = '0;
                ra_next             = '0;
                loop_next           = LW'(d_eff) - LW'(1);
            end
            cips_pkg::OP_RD_START:
            begin
                ra_next = ra_reg + RW'(1);
            end
            cips_pkg::OP_SUM:
            begin
                sum_next  = sum_reg + SW'(rd_pct);
                ra_next   = ra_reg + RW'(1);
                loop_next = loop_reg - LW'(1);
            end
            cips_pkg::OP_AVG_INIT:
            begin
                rem_next  = DW'({sum_reg, {cips_pkg::Q8_SHIFT{1'b0}}});
                dv_next   = DW'(d_eff) << (QW - 1);
                q_next    = '0;
                loop_next = LW'(QW - 1);
            end
            cips_pkg::OP_EMIT_AVG:
            begin
                if (out_free)
                begin
                    last_avg_next    = q_reg[AW-1:0];
                    out_valid_next   = 1'b1;
                    out_data_next    = q_reg[AW-1:0];
                    out_sampled_next = 1'b1;
                end
            end
            cips_pkg::OP_PRIME:
            begin
                if (out_free)
                begin
                    prev_next        = in_reg;
                    primed_next      = 1'b1;
                    last_avg_next    = AW'(cips_pkg::FULL_Q8);
                    out_valid_next   = 1'b1;
                    out_data_next    = AW'(cips_pkg::FULL_Q8);
                    out_sampled_next = 1'b0;
                end
            end
            cips_pkg::OP_REPEAT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_data_next    = last_avg_reg;
                    out_sampled_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_reg      <= '0;
            primed_reg    <= 1'b0;
            pos_reg       <= '0;
            valid_reg     <= '0;
            last_avg_reg  <= AW'(cips_pkg::FULL_Q8);
            cfg_reg       <= CW'(cips_pkg::DEFAULT_DEPTH);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            loop_reg      <= loop_next;
            primed_reg    <= primed_next;
            pos_reg       <= pos_next;
            valid_reg     <= valid_next;
            last_avg_reg  <= last_avg_next;
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg          <= in_next;
        prev_reg        <= prev_next;
        acc_in_reg      <= acc_in_next;
        acc_prev_reg    <= acc_prev_next;
        total_reg       <= total_next;
        idle_reg        <= idle_next;
        rem_reg         <= rem_next;
        dv_reg          <= dv_next;
        q_reg           <= q_next;
        sum_reg         <= sum_next;
        ra_reg          <= ra_next;
        rd_valid_reg    <= rd_valid_next;
        out_data_reg    <= out_data_next;
        out_sampled_reg <= out_sampled_next;
    end

    `CIPS_ASSERT_NXT(a_one_item_in_flight, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "item accepted while one is in flight")
    `CIPS_ASSERT_IMP(a_avg_in_range, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tdata[AW-1:0] <= AW'(cips_pkg::FULL_Q8), "average above full scale")
    `CIPS_ASSERT_NXT(a_pos_below_depth, ctrl.op == cips_pkg::OP_RING,
        32'(pos_reg) < 32'(d_eff), "ring position beyond depth")
    `CIPS_ASSERT_IMP(a_prime_only_once, $rose(primed_reg),
        $past(ctrl.op == cips_pkg::OP_PRIME), "primed set outside prime step")

endmodule

// ===== sim/idle_average_checker.sv =====
// checker for the cpu idle percent smoother: predicts each smoothed idle result and compares
module idle_average_checker
    import cips_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IN_W-1:0]   snap_tdata,
    input  logic              snap_tvalid,
    input  logic              snap_tready,
    input  logic [OUT_W-1:0]  avg_tdata,
    input  logic [0:0]        avg_tuser,
    input  logic              avg_tvalid,
    input  logic              avg_tready,
    input  logic [CFG_W-1:0]  depth_data,
    input  logic              depth_valid,
    input  logic              depth_ready,
    output int                failures,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [AVG_W-1:0] pct_q8;
        logic             sampled;
    } idle_result_t;

    logic [TICK_W-1:0] last_snap [NUM_CNT];
    logic [PCT_W-1:0]  idle_hist [MAX_DEPTH];
    bit                primed_q;
    int unsigned       hist_pos;
    logic [AVG_W-1:0]  avg_q8;
    logic [CFG_W-1:0]  depth_reg;
    idle_result_t      expected_averages [$];
    idle_result_t      oldest;
    int                err_count;
    int                idx;

    assign failures = err_count;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch at %0t ns: %s expected %0d got %0d", $realtime, what, want, got);
        err_count++;
    endtask

    function automatic idle_result_t predict_average(input logic [IN_W-1:0] snap);
        logic [TICK_W-1:0] delta [NUM_CNT];
        logic [TICK_W-1:0] busy;
        logic [TICK_W-1:0] total;
        logic [71:0]       numer;
        logic [71:0]       quot;
        logic [PCT_W-1:0]  pct;
        int unsigned       d;
        int unsigned       sum;
        idle_result_t      r;
        if (!primed_q)
        begin
            for (int k = 0; k < NUM_CNT; k++)
                last_snap[k] = snap[k*TICK_W +: TICK_W];
            primed_q = 1'b1;
            avg_q8   = AVG_W'(FULL_Q8);
            r.pct_q8  = AVG_W'(FULL_Q8);
            r.sampled = 1'b0;
            return r;
        end
        busy = '0;
        for (int k = 0; k < NUM_CNT; k++)
        begin
            delta[k] = snap[k*TICK_W +: TICK_W] - last_snap[k];
            if (k != IDLE_IDX)
                busy += delta[k];
        end
        total = busy + delta[IDLE_IDX];
        if (total == '0)
        begin
            r.pct_q8  = avg_q8;
            r.sampled = 1'b0;
            return r;
        end
        d = (depth_reg == '0) ? DEFAULT_DEPTH : depth_reg;
        if (d > MAX_DEPTH)
            d = MAX_DEPTH;
        hist_pos++;
        if (hist_pos >= d)
            hist_pos = 0;
        numer = 72'(delta[IDLE_IDX]) * 72'(FULL_PCT) + 72'(total >> 1);
        quot  = numer / 72'(total);
        pct   = (quot > 72'(FULL_PCT)) ? PCT_W'(FULL_PCT) : quot[PCT_W-1:0];
        idle_hist[hist_pos] = pct;
        sum = 0;
        for (int i = 0; i < d; i++)
            sum += idle_hist[i];
        avg_q8 = AVG_W'((sum << Q8_SHIFT) / d);
        for (int k = 0; k < NUM_CNT; k++)
            last_snap[k] = snap[k*TICK_W +: TICK_W];
        r.pct_q8  = avg_q8;
        r.sampled = 1'b1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (idx = 0; idx < NUM_CNT; idx++)
                last_snap[idx] = '0;
            for (idx = 0; idx < MAX_DEPTH; idx++)
                idle_hist[idx] = PCT_W'(FULL_PCT);
            primed_q  = 1'b0;
            hist_pos  = 0;
            avg_q8    = AVG_W'(FULL_Q8);
            depth_reg = CFG_W'(DEFAULT_DEPTH);
            expected_averages.delete();
        end
        else
        begin
            if (avg_tvalid && avg_tready)
            begin
                if (expected_averages.size() == 0)
                    report_mismatch("result with nothing outstanding", 0, avg_tdata);
                else
                begin
                    oldest = expected_averages.pop_front();
                    if (avg_tdata !== {{(OUT_W-AVG_W){1'b0}}, oldest.pct_q8})
                        report_mismatch("idle_pct_q8", oldest.pct_q8, avg_tdata);
                    if (avg_tuser[0] !== oldest.sampled)
                        report_mismatch("sampled", oldest.sampled, avg_tuser[0]);
                end
            end
            if (depth_valid && depth_ready)
                depth_reg = depth_data;
            if (snap_tvalid && snap_tready)
                expected_averages.push_back(predict_average(snap_tdata));
        end
        pending = expected_averages.size();
    end

endmodule

// ===== sim/cpu_idle_percent_smoother_unit_tb.sv =====
// testbench top for the cpu idle percent smoother: clock, reset, stimulus and verdict
module cpu_idle_percent_smoother_unit_tb;
    import cips_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 60;
    localparam int NUM_PHASES    = 8;
    localparam int DRAIN_CYCLES  = 120;
    localparam logic [TICK_W-1:0] HALF_RANGE = 64'h8000_0000_0000_0000;
    localparam logic [TICK_W-1:0] ALL_ONES   = '1;

    localparam int USER_IDX    = 0;
    localparam int NICE_IDX    = 1;
    localparam int SYSTEM_IDX  = 2;
    localparam int IOWAIT_IDX  = 4;
    localparam int IRQ_IDX     = 5;
    localparam int SOFTIRQ_IDX = 6;
    localparam int STEAL_IDX   = 7;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic [0:0]        m_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [CFG_W-1:0]  cfg_data      = '0;
    logic              cfg_valid     = 1'b0;
    logic              cfg_ready;

    int                failures;
    int                pending;
    int                cycle_count   = 0;
    int                hold_requests = 0;
    int                holds_served  = 0;
    int                hold_left     = 0;
    int                stall_left    = 0;
    bit                no_gaps       = 1'b0;
    logic [TICK_W-1:0] snap [NUM_CNT];

    cpu_idle_percent_smoother_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_data      (cfg_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready)
    );

    idle_average_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .snap_tdata  (s_axis_tdata),
        .snap_tvalid (s_axis_tvalid),
        .snap_tready (s_axis_tready),
        .avg_tdata   (m_axis_tdata),
        .avg_tuser   (m_axis_tuser),
        .avg_tvalid  (m_axis_tvalid),
        .avg_tready  (m_axis_tready),
        .depth_data  (cfg_data),
        .depth_valid (cfg_valid),
        .depth_ready (cfg_ready),
        .failures    (failures),
        .pending     (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [TICK_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [IN_W-1:0] pack_snapshot();
        logic [IN_W-1:0] v;
        for (int k = 0; k < NUM_CNT; k++)
            v[k*TICK_W +: TICK_W] = snap[k];
        return v;
    endfunction

    // receiver: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready = 1'b0;
            hold_left--;
        end
        else if (hold_requests != holds_served)
        begin
            holds_served++;
            hold_left     = HOLD_CYCLES;
            m_axis_tready = 1'b0;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready = 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready = 1'b1;
            if (!no_gaps)
                stall_left = pick_gap();
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic send_snapshot();
        @(negedge clk);
        s_axis_tdata  = pack_snapshot();
        s_axis_tvalid = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic sender_gap();
        int n;
        n = no_gaps ? 0 : pick_gap();
        repeat (n)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
        end
    endtask

    task automatic send_with_gap();
        send_snapshot();
        sender_gap();
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_depth(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic next_random_snapshot();
        int r;
        int lo;
        int k;
        logic [TICK_W-1:0] delta [NUM_CNT];
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            case ($urandom_range(0, 2))
                0:       lo = 50;
                1:       lo = 20;
                default: lo = 0;
            endcase
            for (k = 0; k < NUM_CNT; k++)
                delta[k] = rand64() >> $urandom_range(lo, 63);
            if (r < 6)
            begin
                for (k = 0; k < NUM_CNT; k++)
                    if (k != IDLE_IDX)
                        delta[k] = '0;
            end
            else if (r < 12)
                delta[IDLE_IDX] = '0;
            for (k = 0; k < NUM_CNT; k++)
                snap[k] += delta[k];
        end
        else if (r < 80)
        begin
            // unchanged counters: zero total
        end
        else if (r < 85)
        begin
            // idle delta wraps past the total
            k = (IDLE_IDX + 1 + $urandom_range(0, NUM_CNT - 2)) % NUM_CNT;
            snap[IDLE_IDX] += HALF_RANGE + $urandom_range(0, 1000);
            snap[k]        += HALF_RANGE;
        end
        else
        begin
            for (k = 0; k < NUM_CNT; k++)
                snap[k] = rand64();
        end
    endtask

    initial
    begin
        int ph;
        int n;
        logic [CFG_W-1:0] phase_depth [NUM_PHASES];
        logic [CFG_W-1:0] depth_val;

        phase_depth = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd2, 7'd30, 7'd0};
        for (int k = 0; k < NUM_CNT; k++)
            snap[k] = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed items at the reset depth
        for (int k = 0; k < NUM_CNT; k++)
            snap[k] = ALL_ONES;
        send_with_gap();
        send_with_gap();
        for (int k = 0; k < NUM_CNT; k++)
            snap[k] = '0;
        send_with_gap();
        snap[IDLE_IDX] += 1000;
        send_with_gap();
        snap[USER_IDX] += 1000;
        send_with_gap();
        snap[USER_IDX] += 5;
        snap[NICE_IDX] -= 5;
        send_with_gap();
        snap[IDLE_IDX]   += HALF_RANGE + 10;
        snap[SYSTEM_IDX] += HALF_RANGE;
        send_with_gap();
        snap[IDLE_IDX]  += 1;
        snap[STEAL_IDX] += 1;
        send_with_gap();
        snap[IDLE_IDX]   += 1;
        snap[IOWAIT_IDX] += 2;
        send_with_gap();
        snap[IDLE_IDX] += 2;
        snap[IRQ_IDX]  += 1;
        send_with_gap();
        snap[IDLE_IDX]    += 1;
        snap[SOFTIRQ_IDX] += 199;
        send_with_gap();
        snap[IDLE_IDX] += 1;
        snap[USER_IDX] += 200;
        send_with_gap();
        for (int k = 0; k < NUM_CNT; k++)
            snap[k] += ALL_ONES;
        send_with_gap();
        snap[USER_IDX] += ALL_ONES;
        send_with_gap();
        snap[IDLE_IDX] += ALL_ONES;
        send_with_gap();
        snap[IDLE_IDX] += 64'd1 << 40;
        snap[NICE_IDX] += 64'd1 << 41;
        send_with_gap();

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            depth_val = (ph == 6) ? CFG_W'($urandom_range(3, 127)) : phase_depth[ph];
            write_depth(depth_val);
            no_gaps = (ph == 1) || (ph == 3);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                next_random_snapshot();
                send_snapshot();
                if (ph == 3 && n == 10)
                    hold_requests++;
                sender_gap();
            end
        end
        no_gaps = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (failures == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/cips_pkg.sv
hw/rtl/cips_ram.sv
hw/rtl/cips_seq.sv
hw/rtl/cpu_idle_percent_smoother_unit.sv
sim/idle_average_checker.sv
sim/cpu_idle_percent_smoother_unit_tb.sv
